### hw/rtl/fcfl_pkg.sv
package fcfl_pkg;

	localparam int FUNC_W     = 2;
	localparam int IDX_W      = 9;
	localparam int STATUS_W   = 2;
	localparam int ADDR_W     = 48;
	localparam int CS_W       = 13;
	localparam int COUNT_W    = 10;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 48;

	localparam int S_TDATA_W  = 16;
	localparam int S_TUSER_W  = 3;
	localparam int M_TDATA_W  = 80;
	localparam int M_TUSER_W  = 2;

	localparam logic [FUNC_W-1:0] FUNC_INIT    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PAGE_BASE  = 1'b1;

	localparam logic [CS_W-1:0] CHUNK_SIZE_RST = 13'd8;

	typedef struct packed {
		logic latch;
		logic init_start;
		logic init_step;
		logic alloc_rd;
		logic alloc_wb;
		logic fail_alloc;
		logic exec_rel;
		logic exec_misc;
	} cmd_t;

	typedef struct packed {
		logic              out_free;
		logic              head_null;
		logic              chunk0_ok;
		logic              next_ok;
		logic [FUNC_W-1:0] func;
	} sts_t;

endpackage

### hw/rtl/fixed_chunk_free_list_allocator_unit.sv
// Fixed-size chunk allocator: one page split into equal chunks kept on a LIFO free list.
// Requests arrive as beats on the s_ channel: s_tuser carries the function (init, allocate,
// release) and the null flag, s_tdata the chunk index to release. Each request gives exactly
// one result beat on the m_ channel: status in m_tuser, granted index and address and the
// free and used counts in m_tdata.
// chunk_size and page_base are written through cfg_wen/cfg_index/cfg_data; the user must
// do so only while idle, as the block itself does not enforce it.
// An accepted request is latched and executed once the output register is free. Release,
// unused codes and an allocate from an empty list finish there; a granted allocate goes on
// to a write-back state (the next link is read from a synchronous memory before the head
// moves); init walks the chunks and writes one link of the next-link memory per cycle.
// One request is in flight at a time: s_tready is high only while the controller is idle.
// A result waits in the output register until m_tready; the block still accepts the next
// request but does not commit it until that register is free.
// Reset restores chunk_size 8, page_base 0, an empty list and zero counts; the link memory
// is left as is and is valid only after an init.
module fixed_chunk_free_list_allocator_unit #(
	parameter int PAGE_BYTES = 4096,
	parameter int MAX_CHUNKS = 512
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [fcfl_pkg::S_TDATA_W-1:0]  s_tdata,  // chunk_index, zero pad
	input  logic [fcfl_pkg::S_TUSER_W-1:0]  s_tuser,  // func, release_null
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [fcfl_pkg::M_TDATA_W-1:0]  m_tdata,  // granted_index, granted_address,
	                                                  // free_chunks, used_chunks, zero pad
	output logic [fcfl_pkg::M_TUSER_W-1:0]  m_tuser,  // status
	input  logic                            cfg_wen,
	input  logic [fcfl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fcfl_pkg::CFG_DATA_W-1:0] cfg_data
);

	import fcfl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	fcfl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	fcfl_datapath #(
		.PAGE_BYTES(PAGE_BYTES),
		.MAX_CHUNKS(MAX_CHUNKS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

### hw/rtl/fcfl_ram.sv
module fcfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/fcfl_ctrl.sv
module fcfl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  fcfl_pkg::sts_t sts,
	output fcfl_pkg::cmd_t cmd
);

	import fcfl_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE      = 4'b0001,
		ST_EXEC      = 4'b0010,
		ST_ALLOC_WB  = 4'b0100,
		ST_INIT_WALK = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.latch = s_tvalid && s_tready;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.out_free) begin
					unique case (sts.func)
						FUNC_INIT: begin
							cmd.init_start = 1'b1;
							state_d = sts.chunk0_ok ? ST_INIT_WALK : ST_IDLE;
						end
						FUNC_ALLOC: begin
							if (sts.head_null) begin
								cmd.fail_alloc = 1'b1;
								state_d = ST_IDLE;
							end else begin
								cmd.alloc_rd = 1'b1;
								state_d = ST_ALLOC_WB;
							end
						end
						FUNC_RELEASE: begin
							cmd.exec_rel = 1'b1;
							state_d = ST_IDLE;
						end
						default: begin
							cmd.exec_misc = 1'b1;
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_ALLOC_WB: begin
				cmd.alloc_wb = 1'b1;
				state_d = ST_IDLE;
			end
			ST_INIT_WALK: begin
				cmd.init_step = 1'b1;
				if (!sts.next_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hw/rtl/fcfl_datapath.sv
module fcfl_datapath #(
	parameter int PAGE_BYTES = 4096,
	parameter int MAX_CHUNKS = 512
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fcfl_pkg::cmd_t                    cmd,
	output fcfl_pkg::sts_t                    sts,
	input  logic [fcfl_pkg::S_TDATA_W-1:0]    s_tdata,
	input  logic [fcfl_pkg::S_TUSER_W-1:0]    s_tuser,
	input  logic                              cfg_wen,
	input  logic [fcfl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fcfl_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [fcfl_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic [fcfl_pkg::M_TUSER_W-1:0]    m_tuser
);

	import fcfl_pkg::*;

	localparam int IW = $clog2(MAX_CHUNKS);
	localparam int LW = $clog2(MAX_CHUNKS + 1);
	localparam int XW = (LW > IDX_W) ? LW : IDX_W + 1;
	localparam int EW = $clog2(PAGE_BYTES + (1 << CS_W)) + 1;
	localparam int PW = IW + CS_W;
	localparam logic [LW-1:0] NULL_LINK = LW'(MAX_CHUNKS);
	localparam logic [EW-1:0] PAGE_LIM  = EW'(PAGE_BYTES);

	logic [CS_W-1:0]     chunk_size_q;
	logic [ADDR_W-1:0]   page_base_q;
	logic [LW-1:0]       head_q;
	logic [LW-1:0]       total_q;
	logic [LW-1:0]       free_q;
	logic [FUNC_W-1:0]   func_q;
	logic [IDX_W-1:0]    idx_q;
	logic                null_q;
	logic [IW-1:0]       walk_q;
	logic [EW-1:0]       end_q;
	logic [PW-1:0]       prod_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [IDX_W-1:0]    res_index_q;
	logic [ADDR_W-1:0]   res_addr_q;

	logic [CS_W-1:0]     cs_eff;
	logic                rel_ok;
	logic                chunk0_ok;
	logic                next_ok;
	logic [LW-1:0]       walk_inc;
	logic                out_load;
	logic                ram_we;
	logic [IW-1:0]       ram_waddr;
	logic [LW-1:0]       ram_wdata;
	logic [LW-1:0]       ram_rdata;
	logic [LW-1:0]       used;

	assign cs_eff    = (chunk_size_q == '0) ? CS_W'(1) : chunk_size_q;
	assign chunk0_ok = EW'(cs_eff) <= PAGE_LIM;
	assign walk_inc  = LW'(walk_q) + LW'(1);
	assign next_ok   = ((end_q + EW'(cs_eff)) <= PAGE_LIM) && (walk_inc < NULL_LINK);
	assign rel_ok    = !null_q && (XW'(idx_q) < XW'(total_q));
	assign used      = total_q - free_q;

	assign sts.out_free  = !out_valid_q || m_tready;
	assign sts.head_null = head_q >= NULL_LINK;
	assign sts.chunk0_ok = chunk0_ok;
	assign sts.next_ok   = next_ok;
	assign sts.func      = func_q;

	assign ram_we    = (cmd.exec_rel && rel_ok) || cmd.init_step;
	assign ram_waddr = cmd.init_step ? walk_q : IW'(idx_q);
	assign ram_wdata = cmd.init_step ? (next_ok ? walk_inc : NULL_LINK) : head_q;

	fcfl_ram #(
		.WIDTH(LW),
		.DEPTH(MAX_CHUNKS)
	) u_next_link (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(head_q[IW-1:0]),
		.rdata(ram_rdata)
	);

	assign out_load = cmd.exec_rel || cmd.exec_misc || cmd.fail_alloc || cmd.alloc_wb
		|| (cmd.init_start && !chunk0_ok) || (cmd.init_step && !next_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_size_q <= CHUNK_SIZE_RST;
			page_base_q  <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_CHUNK_SIZE: chunk_size_q <= cfg_data[CS_W-1:0];
				REG_PAGE_BASE:  page_base_q  <= cfg_data[ADDR_W-1:0];
				default:        chunk_size_q <= chunk_size_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= NULL_LINK;
			total_q <= '0;
			free_q  <= '0;
		end else begin
			priority if (cmd.init_start && !chunk0_ok) begin
				head_q  <= NULL_LINK;
				total_q <= '0;
				free_q  <= '0;
			end else if (cmd.init_step && !next_ok) begin
				head_q  <= '0;
				total_q <= walk_inc;
				free_q  <= walk_inc;
			end else if (cmd.exec_rel && rel_ok) begin
				head_q <= LW'(idx_q);
				if (free_q < total_q) begin
					free_q <= free_q + LW'(1);
				end
			end else if (cmd.alloc_wb) begin
				head_q <= ram_rdata;
				if (free_q != '0) begin
					free_q <= free_q - LW'(1);
				end
			end else begin
				head_q <= head_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q <= s_tuser[FUNC_W-1:0];
			null_q <= s_tuser[FUNC_W];
			idx_q  <= s_tdata[IDX_W-1:0];
		end
		if (cmd.init_start) begin
			walk_q <= '0;
			end_q  <= EW'(cs_eff);
		end else if (cmd.init_step && next_ok) begin
			walk_q <= walk_q + IW'(1);
			end_q  <= end_q + EW'(cs_eff);
		end
		if (cmd.alloc_rd) begin
			prod_q <= PW'(head_q[IW-1:0]) * PW'(chunk_size_q);
		end
		if (out_load) begin
			priority if (cmd.exec_rel && !rel_ok) begin
				res_status_q <= ST_IGNORED;
			end else if (cmd.fail_alloc) begin
				res_status_q <= ST_EMPTY;
			end else begin
				res_status_q <= ST_DONE;
			end
			res_index_q <= cmd.alloc_wb ? IDX_W'(head_q) : '0;
			res_addr_q  <= cmd.alloc_wb ? page_base_q + ADDR_W'(prod_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_status_q;
	assign m_tdata  = M_TDATA_W'({COUNT_W'(used), COUNT_W'(free_q), res_addr_q, res_index_q});

endmodule
